// ===== rtl/iiar_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed insert/remove array package
// Shared constants, operation and status codes, and the control bundle that
// the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package iiar_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 5;
    localparam int LIMIT_W    = 5;
    localparam int FILL_W     = 5;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd4;

    localparam logic REG_LIMIT = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE   = 5'b00001,
        OP_INSERT = 5'b00010,
        OP_REMOVE = 5'b00100,
        OP_READ   = 5'b01000,
        OP_SEARCH = 5'b10000
    } op_t;

    typedef struct packed {
        logic              load;
        op_t               op;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== rtl/iiar_cell.sv =====
// ----------------------------------------------------------------------------
// Indexed insert/remove array storage cell
// Holds one entry, shifts it to or from its neighbors on insert and remove,
// and flags a read or search hit at its own position.
// ----------------------------------------------------------------------------
module iiar_cell #(
    parameter int CAPACITY = iiar_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                        aclk,
    input  iiar_pkg::cell_ctrl_t        ctrl,
    input  logic [CW-1:0]               pos,
    input  logic [CW-1:0]               cnt,
    input  logic [iiar_pkg::DATA_W-1:0] left_entry,
    input  logic [iiar_pkg::DATA_W-1:0] right_entry,
    output logic [iiar_pkg::DATA_W-1:0] entry,
    output logic                        hit
);

    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

    logic [iiar_pkg::DATA_W-1:0] entry_reg, entry_next;
    logic                        hit_reg, hit_next;

    always_comb begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        if (ctrl.load) begin
            hit_next = 1'b0;
            case (ctrl.op)
                iiar_pkg::OP_INSERT: begin
                    if (IDX == pos) begin
                        entry_next = ctrl.value;
                    end else if ((IDX > pos) && (IDX <= cnt)) begin
                        entry_next = left_entry;
                    end
                end
                iiar_pkg::OP_REMOVE: begin
                    if ((IDX >= pos) && (IDX_NEXT < cnt)) begin
                        entry_next = right_entry;
                    end
                end
                iiar_pkg::OP_READ: begin
                    hit_next = (IDX == pos);
                end
                iiar_pkg::OP_SEARCH: begin
                    hit_next = (entry_reg == ctrl.value) && (IDX < cnt);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

// ===== rtl/iiar_select.sv =====
// ----------------------------------------------------------------------------
// Indexed insert/remove array hit selector
// Picks the lowest flagged cell and returns its entry and its position.
// ----------------------------------------------------------------------------
module iiar_select #(
    parameter int CAPACITY = iiar_pkg::CAPACITY_DEF
) (
    input  logic [CAPACITY-1:0]                          hit,
    input  logic [CAPACITY-1:0][iiar_pkg::DATA_W-1:0]    entries,
    output logic                                         found,
    output logic [iiar_pkg::DATA_W-1:0]                  index,
    output logic [iiar_pkg::DATA_W-1:0]                  word
);

    logic [CAPACITY-1:0] lowest;

    assign lowest = hit & (~hit + CAPACITY'(1));
    assign found  = |hit;

    always_comb begin
        index = '0;
        word  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lowest[i]) begin
                index = index | iiar_pkg::DATA_W'(i);
                word  = word | entries[i];
            end
        end
    end

endmodule

// ===== rtl/indexed_insert_remove_array.sv =====
// Pipeline: an accepted request is registered in the cell row and stage one, and its
// result is registered into the output registers when the output is free.
// Throughput: one request per cycle while results are taken; the cell row
// updates and compares at the accept edge, and the hit selector runs next.
// Reset: synchronous and active low; clears the count, the pipeline valid
// flags and sets the capacity limit to 16. Entries are not cleared.
// ----------------------------------------------------------------------------
// Indexed insert/remove array
// An ordered array held in a row of cells with append, insert, remove, read
// and search requests, each answered by one result.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array #(
    parameter int CAPACITY = iiar_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func[2:0], position[7:3], value_in[39:8]
    input  logic [iiar_pkg::S_TDATA_W-1:0]    s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[2:0], value_out[34:3], fill_count[39:35], is_full[40],
    // is_empty[41], zero[47:42]
    output logic [iiar_pkg::M_TDATA_W-1:0]    m_tdata,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iiar_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [iiar_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [iiar_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > iiar_pkg::POS_W) ? CW : iiar_pkg::POS_W;

    logic [iiar_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         busy_reg, busy_next;
    iiar_pkg::status_t            s1_status_reg, s1_status_next;
    logic                         s1_search_reg, s1_search_next;
    logic [CW-1:0]                s1_count_reg, s1_count_next;

    logic                            m_valid_reg, m_valid_next;
    iiar_pkg::status_t               m_status_reg, m_status_next;
    logic [iiar_pkg::DATA_W-1:0]     m_value_reg, m_value_next;
    logic [iiar_pkg::FILL_W-1:0]     m_fill_reg, m_fill_next;
    logic                            m_full_reg, m_full_next;
    logic                            m_empty_reg, m_empty_next;

    logic [iiar_pkg::FUNC_W-1:0] in_func;
    logic [iiar_pkg::POS_W-1:0]  in_pos;
    logic [iiar_pkg::DATA_W-1:0] in_value;

    logic                 accept;
    logic                 out_free;
    logic                 advance;
    logic                 cfg_write;
    logic [WW-1:0]        lim_w;
    logic [WW-1:0]        lim_eff;
    logic [WW-1:0]        cnt_w;
    logic [WW-1:0]        pos_w;
    logic [WW-1:0]        s1_cnt_w;
    logic                 is_full_now;
    logic [CW-1:0]        cell_pos;
    iiar_pkg::cell_ctrl_t cell_ctrl;
    iiar_pkg::op_t        op_sel;

    logic [CAPACITY-1:0]                       hit_q;
    logic [CAPACITY-1:0][iiar_pkg::DATA_W-1:0] entry_q;
    logic                                      sel_found;
    logic [iiar_pkg::DATA_W-1:0]               sel_index;
    logic [iiar_pkg::DATA_W-1:0]               sel_word;

    assign in_func  = s_tdata[2:0];
    assign in_pos   = s_tdata[7:3];
    assign in_value = s_tdata[39:8];

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = busy_reg && out_free;
    assign s_tready = !busy_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == iiar_pkg::REG_LIMIT);
    assign prdata    = (paddr[2] == iiar_pkg::REG_LIMIT)
                       ? iiar_pkg::APB_DATA_W'(limit_reg) : '0;
    assign limit_next = cfg_write ? pwdata[iiar_pkg::LIMIT_W-1:0] : limit_reg;

    assign lim_w   = WW'(limit_reg);
    assign lim_eff = (limit_reg == '0) ? WW'(1)
                     : ((lim_w > WW'(CAPACITY)) ? WW'(CAPACITY) : lim_w);
    assign cnt_w   = WW'(count_reg);
    assign pos_w   = WW'(in_pos);
    assign is_full_now = (cnt_w >= lim_eff);

    always_comb begin
        s1_status_next = iiar_pkg::ST_OK;
        s1_search_next = 1'b0;
        op_sel         = iiar_pkg::OP_NONE;
        cell_pos       = pos_w[CW-1:0];
        count_next     = count_reg;
        case (in_func)
            iiar_pkg::FN_APPEND: begin
                cell_pos = count_reg;
                if (is_full_now) begin
                    s1_status_next = iiar_pkg::ST_FULL;
                end else begin
                    op_sel     = iiar_pkg::OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            iiar_pkg::FN_INSERT: begin
                if (is_full_now) begin
                    s1_status_next = iiar_pkg::ST_FULL;
                end else if (pos_w > cnt_w) begin
                    s1_status_next = iiar_pkg::ST_BADPOS;
                end else begin
                    op_sel     = iiar_pkg::OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            iiar_pkg::FN_REMOVE: begin
                if (count_reg == '0) begin
                    s1_status_next = iiar_pkg::ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    s1_status_next = iiar_pkg::ST_BADPOS;
                end else begin
                    op_sel     = iiar_pkg::OP_REMOVE;
                    count_next = count_reg - CW'(1);
                end
            end
            iiar_pkg::FN_READ: begin
                if (pos_w >= cnt_w) begin
                    s1_status_next = iiar_pkg::ST_BADPOS;
                end else begin
                    op_sel = iiar_pkg::OP_READ;
                end
            end
            iiar_pkg::FN_SEARCH: begin
                op_sel         = iiar_pkg::OP_SEARCH;
                s1_search_next = 1'b1;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            count_next = count_reg;
        end
        s1_count_next = count_next;
    end

    assign cell_ctrl.load  = accept;
    assign cell_ctrl.op    = op_sel;
    assign cell_ctrl.value = in_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [iiar_pkg::DATA_W-1:0] left_w;
        logic [iiar_pkg::DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = entry_q[i];
        end else begin : g_left
            assign left_w = entry_q[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = entry_q[i];
        end else begin : g_right
            assign right_w = entry_q[i+1];
        end

        iiar_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl),
            .pos         (cell_pos),
            .cnt         (count_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_q[i]),
            .hit         (hit_q[i])
        );
    end

    iiar_select #(
        .CAPACITY (CAPACITY)
    ) u_select (
        .hit     (hit_q),
        .entries (entry_q),
        .found   (sel_found),
        .index   (sel_index),
        .word    (sel_word)
    );

    assign busy_next = accept ? 1'b1 : (advance ? 1'b0 : busy_reg);
    assign s1_cnt_w  = WW'(s1_count_reg);

    always_comb begin
        m_valid_next  = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_fill_next   = m_fill_reg;
        m_full_next   = m_full_reg;
        m_empty_next  = m_empty_reg;
        if (advance) begin
            if (s1_search_reg) begin
                m_status_next = sel_found ? iiar_pkg::ST_OK : iiar_pkg::ST_NOTFOUND;
                m_value_next  = sel_index;
            end else begin
                m_status_next = s1_status_reg;
                m_value_next  = sel_word;
            end
            m_fill_next  = s1_cnt_w[iiar_pkg::FILL_W-1:0];
            m_full_next  = (s1_cnt_w >= lim_eff);
            m_empty_next = (s1_count_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= iiar_pkg::LIMIT_RESET;
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            limit_reg   <= limit_next;
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_status_reg <= s1_status_next;
            s1_search_reg <= s1_search_next;
            s1_count_reg  <= s1_count_next;
        end
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_fill_reg   <= m_fill_next;
        m_full_reg   <= m_full_next;
        m_empty_reg  <= m_empty_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_empty_reg, m_full_reg, m_fill_reg, m_value_reg, m_status_reg};

endmodule

// ===== rtl/iiar_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed insert/remove array port checker
// Watches the result channel for stable stalled results and for status,
// count and flag combinations that the array can never report.
// ----------------------------------------------------------------------------
module iiar_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [iiar_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [iiar_pkg::STATUS_W-1:0] status_w;
    logic [iiar_pkg::DATA_W-1:0]   value_w;
    logic [iiar_pkg::FILL_W-1:0]   fill_w;
    logic                          full_w;
    logic                          empty_w;

    assign status_w = m_tdata[2:0];
    assign value_w  = m_tdata[34:3];
    assign fill_w   = m_tdata[39:35];
    assign full_w   = m_tdata[40];
    assign empty_w  = m_tdata[41];

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Stalled result changed.");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (empty_w == (fill_w == '0)))
        else $error("Empty flag disagrees with fill count.");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_w == iiar_pkg::ST_FULL)) |-> (full_w && !empty_w))
        else $error("Full status without full flag.");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_w == iiar_pkg::ST_EMPTY)) |-> empty_w)
        else $error("Empty status with stored entries.");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_w != iiar_pkg::ST_OK)) |-> (value_w == '0))
        else $error("Failed request returned a nonzero value.");

endmodule

bind indexed_insert_remove_array iiar_checker u_iiar_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Indexed insert/remove array testbench
// Drives append, insert, remove, read and search requests into the stream
// input and keeps a shadow copy of the array and its capacity limit. Every
// result is checked field by field against that copy. The test runs directed
// corner cases, the capacity limit at its extremes, random phases under
// several limits, a long result stall and a final stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DATA_W     = iiar_pkg::DATA_W;
    localparam int FUNC_W     = iiar_pkg::FUNC_W;
    localparam int POS_W      = iiar_pkg::POS_W;
    localparam int LIMIT_W    = iiar_pkg::LIMIT_W;
    localparam int FILL_W     = iiar_pkg::FILL_W;
    localparam int S_TDATA_W  = iiar_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = iiar_pkg::M_TDATA_W;
    localparam int APB_ADDR_W = iiar_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = iiar_pkg::APB_DATA_W;

    localparam int CAPACITY     = iiar_pkg::CAPACITY_DEF;
    localparam int FUNC_MAX     = (1 << FUNC_W) - 1;
    localparam int STALL_LIMIT  = 1000;
    localparam int LATENCY      = 2;

    localparam logic [POS_W-1:0]      POS_MAX     = '1;
    localparam logic [FUNC_W-1:0]     FN_SPARE_LO = iiar_pkg::FN_SEARCH + 1'b1;
    localparam logic [FUNC_W-1:0]     FN_SPARE_HI = '1;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR  = {iiar_pkg::REG_LIMIT, 2'b00};

    typedef struct {
        iiar_pkg::status_t status;
        logic [DATA_W-1:0] value;
        logic [FILL_W-1:0] fill;
        logic              full;
        logic              empty;
    } array_result_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [DATA_W-1:0]      shadow_words [0:CAPACITY-1];
    int                     shadow_count = 0;
    logic [LIMIT_W-1:0]     shadow_limit = iiar_pkg::LIMIT_RESET;
    array_result_t          pending_results[$];

    int mismatch_count = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;

    indexed_insert_remove_array u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int effective_limit();
        int lim = int'(shadow_limit);
        if (lim < 1) lim = 1;
        if (lim > CAPACITY) lim = CAPACITY;
        return lim;
    endfunction

    function automatic array_result_t apply_array_op(logic [FUNC_W-1:0] func,
                                                     logic [POS_W-1:0] pos,
                                                     logic [DATA_W-1:0] word);
        array_result_t r;
        int lim;
        int idx;
        bit was_full;
        bit hit;
        lim = effective_limit();
        was_full = shadow_count >= lim;
        r.status = iiar_pkg::ST_OK;
        r.value = '0;
        hit = 1'b0;
        case (func)
            iiar_pkg::FN_APPEND: begin
                if (was_full) begin
                    r.status = iiar_pkg::ST_FULL;
                end else begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            iiar_pkg::FN_INSERT: begin
                if (was_full) begin
                    r.status = iiar_pkg::ST_FULL;
                end else if (int'(pos) > shadow_count) begin
                    r.status = iiar_pkg::ST_BADPOS;
                end else begin
                    for (idx = shadow_count; idx > int'(pos); idx--)
                        shadow_words[idx] = shadow_words[idx-1];
                    shadow_words[int'(pos)] = word;
                    shadow_count++;
                end
            end
            iiar_pkg::FN_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = iiar_pkg::ST_EMPTY;
                end else if (int'(pos) >= shadow_count) begin
                    r.status = iiar_pkg::ST_BADPOS;
                end else begin
                    for (idx = int'(pos); idx + 1 < shadow_count; idx++)
                        shadow_words[idx] = shadow_words[idx+1];
                    shadow_count--;
                end
            end
            iiar_pkg::FN_READ: begin
                if (int'(pos) >= shadow_count) r.status = iiar_pkg::ST_BADPOS;
                else r.value = shadow_words[int'(pos)];
            end
            iiar_pkg::FN_SEARCH: begin
                r.status = iiar_pkg::ST_NOTFOUND;
                for (idx = 0; idx < shadow_count && !hit; idx++) begin
                    if (shadow_words[idx] == word) begin
                        hit = 1'b1;
                        r.status = iiar_pkg::ST_OK;
                        r.value = DATA_W'(idx);
                    end
                end
            end
            default: ;
        endcase
        r.fill = FILL_W'(shadow_count);
        r.full = shadow_count >= lim;
        r.empty = shadow_count == 0;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected 0x%0h, actual 0x%0h", field, want, got);
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] word);
        int gap;
        if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {word, pos, func};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_array_op(func, pos, word));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [LIMIT_W-1:0] val,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= LIMIT_ADDR;
        pwdata  <= APB_DATA_W'(val);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (write) shadow_limit = val;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The array must be idle here: every expected result has arrived.
    task automatic set_limit(input logic [LIMIT_W-1:0] val);
        logic [APB_DATA_W-1:0] rdata;
        wait_drained();
        apb_access(1'b1, val, rdata);
        apb_access(1'b0, '0, rdata);
        if (rdata[LIMIT_W-1:0] !== shadow_limit)
            report_mismatch("capacity_limit readback", DATA_W'(shadow_limit), rdata);
    endtask

    task automatic test_directed();
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata[LIMIT_W-1:0] !== iiar_pkg::LIMIT_RESET)
            report_mismatch("capacity_limit after reset", DATA_W'(iiar_pkg::LIMIT_RESET),
                            rdata);
        send_request(iiar_pkg::FN_READ,   5'd0, 32'h0);
        send_request(iiar_pkg::FN_REMOVE, 5'd0, 32'h0);
        send_request(iiar_pkg::FN_SEARCH, 5'd0, 32'h0);
        send_request(FN_SPARE_LO,         POS_MAX, '1);
        send_request(FN_SPARE_HI,         5'd0, 32'h5555_aaaa);
        send_request(iiar_pkg::FN_APPEND, 5'd0, 32'h7fff_ffff);
        send_request(iiar_pkg::FN_APPEND, POS_MAX, 32'h8000_0000);
        send_request(iiar_pkg::FN_INSERT, 5'd0, 32'h0);
        send_request(iiar_pkg::FN_INSERT, 5'd3, '1);
        send_request(iiar_pkg::FN_INSERT, 5'd5, 32'h1234_5678);
        send_request(iiar_pkg::FN_INSERT, POS_MAX, 32'h1234_5678);
        send_request(iiar_pkg::FN_READ,   5'd0, 32'h0);
        send_request(iiar_pkg::FN_READ,   5'd3, 32'h0);
        send_request(iiar_pkg::FN_READ,   5'd4, 32'h0);
        send_request(iiar_pkg::FN_READ,   POS_MAX, 32'h0);
        send_request(iiar_pkg::FN_SEARCH, 5'd0, 32'h8000_0000);
        send_request(iiar_pkg::FN_APPEND, 5'd0, 32'h0);
        send_request(iiar_pkg::FN_SEARCH, 5'd0, 32'h0);
        send_request(iiar_pkg::FN_SEARCH, 5'd0, 32'h1234_5678);
        send_request(iiar_pkg::FN_REMOVE, 5'd1, 32'h0);
        send_request(iiar_pkg::FN_REMOVE, 5'd4, 32'h0);
        send_request(iiar_pkg::FN_REMOVE, 5'd3, 32'h0);
        send_request(iiar_pkg::FN_READ,   5'd1, 32'h0);
        wait_drained();
    endtask

    // Limits outside the valid range, full refusals and a limit lowered
    // below the number of stored entries.
    task automatic test_capacity();
        set_limit(5'd0);
        send_request(iiar_pkg::FN_APPEND, 5'd0, 32'h1);
        send_request(iiar_pkg::FN_INSERT, 5'd0, 32'h2);
        send_request(iiar_pkg::FN_INSERT, POS_MAX, 32'h3);
        send_request(iiar_pkg::FN_REMOVE, 5'd0, 32'h0);
        send_request(iiar_pkg::FN_READ,   5'd0, 32'h0);
        set_limit(5'd31);
        while (shadow_count < CAPACITY)
            send_request(iiar_pkg::FN_APPEND, 5'd0, $urandom);
        send_request(iiar_pkg::FN_APPEND, 5'd0, 32'h4);
        send_request(iiar_pkg::FN_INSERT, 5'd0, 32'h5);
        send_request(iiar_pkg::FN_READ,   POS_W'(CAPACITY - 1), 32'h0);
        set_limit(5'd1);
        send_request(iiar_pkg::FN_APPEND, 5'd0, 32'h6);
        send_request(iiar_pkg::FN_REMOVE, POS_W'(CAPACITY - 1), 32'h0);
        send_request(iiar_pkg::FN_READ,   POS_W'(CAPACITY - 2), 32'h0);
        set_limit(5'd16);
        send_request(iiar_pkg::FN_INSERT, 5'd2, 32'h7);
        wait_drained();
    endtask

    task automatic run_random(input int count);
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 9);
            if (k < 3) word = $urandom_range(0, 7);
            else if (k == 3) word = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            else word = $urandom;
            if ($urandom_range(0, 99) < 6) begin
                func = FUNC_W'($urandom_range(0, FUNC_MAX));
                pos  = POS_W'($urandom_range(0, POS_MAX));
            end else begin
                k = $urandom_range(0, 99);
                if (shadow_count >= effective_limit() && k < 60) func = iiar_pkg::FN_REMOVE;
                else if (k < 22) func = iiar_pkg::FN_APPEND;
                else if (k < 44) func = iiar_pkg::FN_INSERT;
                else if (k < 62) func = iiar_pkg::FN_REMOVE;
                else if (k < 80) func = iiar_pkg::FN_READ;
                else func = iiar_pkg::FN_SEARCH;
                case (func)
                    iiar_pkg::FN_INSERT: pos = POS_W'($urandom_range(0, shadow_count));
                    iiar_pkg::FN_REMOVE, iiar_pkg::FN_READ: begin
                        pos = (shadow_count > 0) ? POS_W'($urandom_range(0, shadow_count - 1))
                                                 : '0;
                    end
                    default: pos = POS_W'($urandom_range(0, POS_MAX));
                endcase
                if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, POS_MAX));
                if (func == iiar_pkg::FN_SEARCH && shadow_count > 0 && $urandom_range(0, 1) != 0)
                    word = shadow_words[$urandom_range(0, shadow_count - 1)];
            end
            send_request(func, pos, word);
        end
        wait_drained();
    endtask

    task automatic test_random_limits();
        send_gap_pct = 30;
        recv_stall_pct = 10;
        set_limit(5'd16);
        run_random(50);
        send_gap_pct = 20;
        set_limit(5'd4);
        run_random(50);
        set_limit(5'd1);
        run_random(50);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_limit(5'd31);
        run_random(50);
        send_gap_pct = 30;
        recv_stall_pct = 15;
        set_limit(5'd0);
        run_random(50);
        set_limit(LIMIT_W'($urandom_range(2, 15)));
        run_random(50);
    endtask

    task automatic test_result_stall();
        set_limit(5'd16);
        send_gap_pct = 0;
        hold_cycles = 150;
        run_random(40);
    endtask

    task automatic test_no_idle();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_limit(LIMIT_W'($urandom_range(8, 16)));
        run_random(60);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_capacity();
        test_random_limits();
        test_result_stall();
        test_no_idle();
        wait_drained();
        repeat (LATENCY + 4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        array_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", '0, m_tdata[DATA_W-1:0]);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", DATA_W'(want.status), DATA_W'(m_tdata[2:0]));
                if (m_tdata[34:3] !== want.value)
                    report_mismatch("value_out", want.value, m_tdata[34:3]);
                if (m_tdata[39:35] !== want.fill)
                    report_mismatch("fill_count", DATA_W'(want.fill), DATA_W'(m_tdata[39:35]));
                if (m_tdata[40] !== want.full)
                    report_mismatch("is_full", DATA_W'(want.full), DATA_W'(m_tdata[40]));
                if (m_tdata[41] !== want.empty)
                    report_mismatch("is_empty", DATA_W'(want.empty), DATA_W'(m_tdata[41]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
